// ----- rtl/core/grouped_weight_dequant_top_assert.svh -----
// Assertion macros used by the checker file of the dequantizer.
`ifndef GROUPED_WEIGHT_DEQUANT_TOP_ASSERT_SVH
`define GROUPED_WEIGHT_DEQUANT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GWD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GWD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed: lbl");

`endif

// ----- rtl/core/gwd_pkg.sv -----
package gwd_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [7:0] OFF_INT4 = 8'd8;
	localparam logic [7:0] OFF_INT8 = 8'd128;
	localparam int NIB_W = 4;

	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_ASYM = 1'b1;

	typedef enum logic [1:0] {
		FMT_INT4 = 2'd0,
		FMT_INT8 = 2'd1,
		FMT_FP16 = 2'd2,
		FMT_BF16 = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [15:0] raw_word;
		logic [31:0] scale_bits;
		logic [31:0] zero_bits;
		logic last_in;
	} in_t;

	typedef struct packed {
		logic [31:0] value_bits;
		logic last_out;
	} out_t;

	// One result's worth of work after the nibble split.
	typedef struct packed {
		logic [7:0] q;
		logic [15:0] raw;
		logic [31:0] scale;
		logic [31:0] zero;
		logic last;
	} sub_t;

	// Load enables for the two register stages of an arithmetic unit.
	typedef struct packed {
		logic a;
		logic b;
	} stage_en_t;

	typedef struct packed {
		logic sign;
		logic nan;
		logic inf;
		logic zero;
		logic [9:0] ex;
		logic [31:0] prod;
	} mul_raw_t;

	typedef struct packed {
		logic sign;
		logic nan;
		logic inf;
		logic zero;
		logic [9:0] ex;
		logic [27:0] sum;
	} add_raw_t;

	function automatic logic [4:0] lzc32(input logic [31:0] v);
		logic [4:0] z;
		z = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				z = 5'(31 - i);
			end
		end
		return z;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] z;
		z = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) begin
				z = 5'(26 - i);
			end
		end
		return z;
	endfunction

	function automatic logic [3:0] lzc10(input logic [9:0] v);
		logic [3:0] z;
		z = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (v[i]) begin
				z = 4'(9 - i);
			end
		end
		return z;
	endfunction

	// sig holds the hidden bit at 26 and guard, round and sticky in [2:0].
	// ex is never below 1; an unnormalized sig at ex 1 is a subnormal.
	function automatic logic [31:0] round_pack(input logic s, input logic [9:0] ex,
			input logic [26:0] sig);
		logic inc;
		logic [24:0] m;
		logic [23:0] m24;
		logic [9:0] exr;
		inc = sig[2] & (sig[3] | sig[1] | sig[0]);
		m = {1'b0, sig[26:3]} + {24'd0, inc};
		if (m[24]) begin
			m24 = m[24:1];
			exr = ex + 10'd1;
		end else begin
			m24 = m[23:0];
			exr = ex;
		end
		if (exr >= 10'd255) begin
			return {s, 8'hFF, 23'd0};
		end else if (!m24[23]) begin
			return {s, 8'd0, m24[22:0]};
		end
		return {s, exr[7:0], m24[22:0]};
	endfunction

	// Integer code times a single: raw significand product.
	function automatic mul_raw_t mul_pre(input logic [7:0] q, input logic [31:0] f);
		logic [7:0] e;
		logic [22:0] fr;
		logic is_nan;
		logic is_inf;
		logic is_zero;
		mul_raw_t r;
		e = f[30:23];
		fr = f[22:0];
		is_nan = (e == 8'hFF) && (fr != 23'd0);
		is_inf = (e == 8'hFF) && (fr == 23'd0);
		is_zero = (e == 8'd0) && (fr == 23'd0);
		r.sign = f[31];
		r.nan = is_nan || (is_inf && (q == 8'd0));
		r.inf = is_inf && (q != 8'd0);
		r.zero = is_zero || (q == 8'd0);
		r.ex = {2'b00, (e == 8'd0) ? 8'd1 : e} + 10'd8;
		r.prod = 32'({e != 8'd0, fr}) * 32'(q);
		return r;
	endfunction

	function automatic logic [31:0] mul_post(input mul_raw_t r);
		logic [4:0] z;
		logic [9:0] lim;
		logic [9:0] sh;
		logic [31:0] pn;
		logic [26:0] sig;
		z = lzc32(r.prod);
		lim = r.ex - 10'd1;
		sh = ({5'd0, z} > lim) ? lim : {5'd0, z};
		pn = r.prod << sh;
		sig = {pn[31:6], pn[5] | (|pn[4:0])};
		if (r.nan) begin
			return CANON_NAN;
		end else if (r.inf) begin
			return {r.sign, 8'hFF, 23'd0};
		end else if (r.zero) begin
			return {r.sign, 31'd0};
		end
		return round_pack(r.sign, r.ex - sh, sig);
	endfunction

	// Swap by magnitude, align the smaller operand, add or subtract.
	function automatic add_raw_t add_pre(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0] ex_x;
		logic [7:0] ex_y;
		logic [7:0] d;
		logic [26:0] sx;
		logic [26:0] sy;
		logic [26:0] ys;
		logic [26:0] msk;
		logic a_nan;
		logic b_nan;
		logic a_inf;
		logic b_inf;
		logic sub;
		add_raw_t r;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex_x = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ex_y = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		sx = {x[30:23] != 8'd0, x[22:0], 3'b000};
		sy = {y[30:23] != 8'd0, y[22:0], 3'b000};
		d = ex_x - ex_y;
		msk = ~(27'h7FF_FFFF << d);
		ys = (sy >> d) | {26'd0, |(sy & msk)};
		sub = x[31] ^ y[31];
		r.sum = sub ? ({1'b0, sx} - {1'b0, ys}) : ({1'b0, sx} + {1'b0, ys});
		r.nan = a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
		r.inf = a_inf || b_inf;
		r.zero = (r.sum == 28'd0);
		r.ex = {2'b00, ex_x};
		// An exact cancellation rounds to +0 unless both operands are negative.
		r.sign = r.inf ? (a_inf ? a[31] : b[31]) : (r.zero ? (x[31] & y[31]) : x[31]);
		return r;
	endfunction

	function automatic logic [31:0] add_post(input add_raw_t r);
		logic [4:0] z;
		logic [9:0] lim;
		logic [9:0] sh;
		logic [26:0] sig;
		logic [9:0] exn;
		z = lzc27(r.sum[26:0]);
		lim = r.ex - 10'd1;
		sh = ({5'd0, z} > lim) ? lim : {5'd0, z};
		if (r.sum[27]) begin
			sig = {r.sum[27:2], r.sum[1] | r.sum[0]};
			exn = r.ex + 10'd1;
		end else begin
			sig = r.sum[26:0] << sh;
			exn = r.ex - sh;
		end
		if (r.nan) begin
			return CANON_NAN;
		end else if (r.inf) begin
			return {r.sign, 8'hFF, 23'd0};
		end else if (r.zero) begin
			return {r.sign, 31'd0};
		end
		return round_pack(r.sign, exn, sig);
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] z;
		logic [10:0] mn;
		logic [7:0] es;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		z = lzc10(m);
		mn = {1'b0, m} << (z + 4'd1);
		es = 8'd112 - {4'd0, z};
		if (e == 5'h1F) begin
			return {s, 8'hFF, m, 13'd0};
		end else if (e == 5'd0) begin
			if (m == 10'd0) begin
				return {s, 31'd0};
			end
			return {s, es, mn[9:0], 13'd0};
		end
		return {s, 8'd112 + {3'd0, e}, m, 13'd0};
	endfunction

endpackage

// ----- rtl/core/gwd_split.sv -----
module gwd_split (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gwd_pkg::in_t in_data,
	input gwd_pkg::fmt_t fmt,
	output logic sub_valid,
	input logic sub_ready,
	output gwd_pkg::sub_t sub
);

	gwd_pkg::in_t buf_q;
	logic full_q;
	logic second_q;
	logic two;
	logic final_now;
	logic take;
	logic accept;
	logic [7:0] byte_v;

	assign two = (fmt == gwd_pkg::FMT_INT4);
	assign final_now = !two || second_q;
	assign take = full_q && sub_ready;
	// The buffer frees in the same cycle that its last piece leaves.
	assign in_stall = full_q && !(take && final_now);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (accept) begin
				full_q <= 1'b1;
			end else if (take && final_now) begin
				full_q <= 1'b0;
			end
			if (take) begin
				second_q <= two && !second_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= in_data;
		end
	end

	assign byte_v = buf_q.raw_word[7:0];
	assign sub_valid = full_q;

	always_comb begin
		if (!two) begin
			sub.q = byte_v;
		end else if (second_q) begin
			sub.q = {4'd0, byte_v[gwd_pkg::NIB_W-1:0]};
		end else begin
			sub.q = {4'd0, byte_v[2*gwd_pkg::NIB_W-1:gwd_pkg::NIB_W]};
		end
		sub.raw = buf_q.raw_word;
		sub.scale = buf_q.scale_bits;
		sub.zero = buf_q.zero_bits;
		sub.last = buf_q.last_in && final_now;
	end

endmodule

// ----- rtl/core/gwd_fmul.sv -----
module gwd_fmul (
	input logic clk,
	input gwd_pkg::stage_en_t en,
	input logic [7:0] q,
	input logic [31:0] f,
	output logic [31:0] y
);

	gwd_pkg::mul_raw_t raw_s1;

	always_ff @(posedge clk) begin
		if (en.a) begin
			raw_s1 <= gwd_pkg::mul_pre(q, f);
		end
		if (en.b) begin
			y <= gwd_pkg::mul_post(raw_s1);
		end
	end

endmodule

// ----- rtl/core/gwd_fadd.sv -----
module gwd_fadd (
	input logic clk,
	input gwd_pkg::stage_en_t en,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic [31:0] y
);

	gwd_pkg::add_raw_t raw_s1;

	always_ff @(posedge clk) begin
		if (en.a) begin
			raw_s1 <= gwd_pkg::add_pre(a, b);
		end
		if (en.b) begin
			y <= gwd_pkg::add_post(raw_s1);
		end
	end

endmodule

// ----- rtl/core/grouped_weight_dequant_top.sv -----
// Group-wise weight dequantizer: int4/int8 codes, fp16/bf16 to IEEE singles.
// Input channel in_valid/in_stall/in_data carries one weight word with its
// group's scale and zero; output channel out_valid/out_stall/out_data carries
// one single-precision value per transaction, with last_out on the final value
// of a word marked last_in. Int4 words give two values (high nibble first),
// every other format gives one.
// cfg_we/cfg_index/cfg_data write the format and asymmetric registers; write
// them only while no word is in flight.
// The first value of a word passes the input buffer and the six register
// stages below before it appears. Throughput: one value per cycle while
// out_stall is low, so one word per cycle in int8, fp16 and bf16 modes; in
// int4 mode the single input buffer hands out the two nibbles in turn.
// The datapath is six register stages: multiply, multiply round, bias add
// align, bias add round, final add align, final add round.
// Reset clears all valid bits and sets format int4, symmetric.
// A stalled output holds its value; stages behind it fill up and then stall
// the input, and no transaction is lost or repeated.
module grouped_weight_dequant_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gwd_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output gwd_pkg::out_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [1:0] cfg_data
);

	typedef struct packed {
		logic last;
		logic [31:0] conv;
	} side_t;

	gwd_pkg::fmt_t fmt_q;
	logic asym_q;

	logic sub_valid;
	gwd_pkg::sub_t sub;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [31:0] zero_s1, zero_s2;
	logic [31:0] sp_s3, sp_s4;
	logic [31:0] prod_s3, prod_s4;

	logic [31:0] prod_y, sp_y, bias_y, res_y, bias;
	logic [7:0] off;
	logic [31:0] conv;
	logic arith;

	gwd_split u_split (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.fmt(fmt_q),
		.sub_valid(sub_valid),
		.sub_ready(rdy1),
		.sub(sub)
	);

	assign rdy6 = !v_s6 || !out_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= gwd_pkg::FMT_INT4;
			asym_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == gwd_pkg::REG_FORMAT)) begin
				fmt_q <= gwd_pkg::fmt_t'(cfg_data);
			end
			if (cfg_we && (cfg_index == gwd_pkg::REG_ASYM)) begin
				asym_q <= cfg_data[0];
			end
			if (rdy1) v_s1 <= sub_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	assign off = (fmt_q == gwd_pkg::FMT_INT4) ? gwd_pkg::OFF_INT4 : gwd_pkg::OFF_INT8;
	assign conv = (fmt_q == gwd_pkg::FMT_FP16) ? gwd_pkg::half_to_single(sub.raw)
		: {sub.raw, 16'd0};

	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1 <= '{last: sub.last, conv: conv};
			zero_s1 <= sub.zero;
		end
		if (rdy2) begin
			side_s2 <= side_s1;
			zero_s2 <= zero_s1;
		end
		if (rdy3) begin
			side_s3 <= side_s2;
			sp_s3 <= sp_y;
			prod_s3 <= prod_y;
		end
		if (rdy4) begin
			side_s4 <= side_s3;
			sp_s4 <= sp_s3;
			prod_s4 <= prod_s3;
		end
		if (rdy5) side_s5 <= side_s4;
		if (rdy6) side_s6 <= side_s5;
	end

	gwd_fmul u_prod (
		.clk(clk),
		.en('{a: rdy1, b: rdy2}),
		.q(sub.q),
		.f(sub.scale),
		.y(prod_y)
	);

	// Offset times scale: the offset is subtracted, so the sign
	// of scale is flipped and the magnitude multiplied by 8 or 128.
	gwd_fmul u_sp (
		.clk(clk),
		.en('{a: rdy1, b: rdy2}),
		.q(off),
		.f({~sub.scale[31], sub.scale[30:0]}),
		.y(sp_y)
	);

	gwd_fadd u_bias (
		.clk(clk),
		.en('{a: rdy3, b: rdy4}),
		.a(zero_s2),
		.b(sp_y),
		.y(bias_y)
	);

	assign bias = asym_q ? bias_y : sp_s4;

	gwd_fadd u_res (
		.clk(clk),
		.en('{a: rdy5, b: rdy6}),
		.a(prod_s4),
		.b(bias),
		.y(res_y)
	);

	assign arith = (fmt_q == gwd_pkg::FMT_INT4) || (fmt_q == gwd_pkg::FMT_INT8);
	assign out_valid = v_s6;
	assign out_data.value_bits = arith ? res_y : side_s6.conv;
	assign out_data.last_out = side_s6.last;

endmodule

// ----- rtl/core/gwd_checker.sv -----
`include "grouped_weight_dequant_top_assert.svh"

module gwd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input gwd_pkg::out_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [1:0] cfg_data
);

	gwd_pkg::fmt_t fmt_q;
	logic arith;
	logic out_nan;
	logic in_acc;
	logic is_int4;
	logic is_bf16;

	// Shadow of the format register, rebuilt from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= gwd_pkg::FMT_INT4;
		end else if (cfg_we && (cfg_index == gwd_pkg::REG_FORMAT)) begin
			fmt_q <= gwd_pkg::fmt_t'(cfg_data);
		end
	end

	assign arith = (fmt_q == gwd_pkg::FMT_INT4) || (fmt_q == gwd_pkg::FMT_INT8);
	assign is_int4 = (fmt_q == gwd_pkg::FMT_INT4);
	assign is_bf16 = (fmt_q == gwd_pkg::FMT_BF16);
	assign in_acc = in_valid && !in_stall;
	assign out_nan = (out_data.value_bits[30:23] == 8'hFF)
		&& (out_data.value_bits[22:0] != 23'd0);

	`GWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	// An int4 word occupies the input buffer for two nibble transactions.
	`GWD_ASSERT_NEXT(a_int4_two_beats, in_acc && is_int4, in_stall)
	`GWD_ASSERT_IMPLY(a_bf16_low_zero, out_valid && is_bf16, out_data.value_bits[15:0] == 16'd0)
	`GWD_ASSERT_IMPLY(a_canon_nan, out_valid && arith && out_nan, out_data.value_bits == gwd_pkg::CANON_NAN)

endmodule

bind grouped_weight_dequant_top gwd_checker u_gwd_checker (.*);
